FILE: rtl/core/divide_three_by_two_limb_preinverse_core_defines.svh
// ============================================================================
// Assertion macros for the three-by-two limb divider
// Shared property shorthands. Each use names the clock clk_i and the
// active-low reset rst_ni of the module where it stands.
// ============================================================================
`ifndef DIVIDE_THREE_BY_TWO_LIMB_PREINVERSE_CORE_DEFINES_SVH
`define DIVIDE_THREE_BY_TWO_LIMB_PREINVERSE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dtb_pkg.sv
// ============================================================================
// dtb_pkg
// Register map and bus constants shared by the register file and the top level.
// ============================================================================
package dtb_pkg;

  // Configuration bus geometry.
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;

  // Register index, taken from byte address bits [3:2].
  typedef enum logic [1:0] {
    REG_DIVISOR_HIGH = 2'd0,
    REG_DIVISOR_LOW  = 2'd1,
    REG_RECIPROCAL   = 2'd2
  } dtb_reg_e;

endpackage

FILE: rtl/core/dtb_channels.sv
// ============================================================================
// Stream channels
// Valid/ready channels for dividend items and result items.
// ============================================================================

// Dividend channel: three limbs, most significant first.
interface dtb_dividend_if #(
  parameter int unsigned LIMB_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [LIMB_WIDTH-1:0] dividend_top;
  logic [LIMB_WIDTH-1:0] dividend_mid;
  logic [LIMB_WIDTH-1:0] dividend_bottom;

  modport source (
    output valid, dividend_top, dividend_mid, dividend_bottom,
    input  ready
  );
  modport sink (
    input  valid, dividend_top, dividend_mid, dividend_bottom,
    output ready
  );
endinterface

// Result channel: quotient limb and two-limb remainder.
interface dtb_result_if #(
  parameter int unsigned LIMB_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [LIMB_WIDTH-1:0] quotient;
  logic [LIMB_WIDTH-1:0] remainder_high;
  logic [LIMB_WIDTH-1:0] remainder_low;

  modport source (
    output valid, quotient, remainder_high, remainder_low,
    input  ready
  );
  modport sink (
    input  valid, quotient, remainder_high, remainder_low,
    output ready
  );
endinterface

FILE: rtl/core/dtb_regs.sv
// ============================================================================
// dtb_regs
// APB register file holding the divisor limbs and the reciprocal.
// ============================================================================
`include "divide_three_by_two_limb_preinverse_core_defines.svh"

module dtb_regs import dtb_pkg::*; #(
  parameter int unsigned LIMB_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output logic [LIMB_WIDTH-1:0]     d1_o,
  output logic [LIMB_WIDTH-1:0]     d0_o,
  output logic [LIMB_WIDTH-1:0]     recip_o
);

  logic [LIMB_WIDTH-1:0] d1_q, d0_q, recip_q;
  logic [1:0]            reg_idx;
  logic                  wr_en;
  logic                  wr_d1, wr_recip;
  logic [LIMB_WIDTH-1:0] wr_data;

  // The bus never inserts wait states.
  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign wr_en    = psel && penable && pwrite;
  assign wr_data  = pwdata[LIMB_WIDTH-1:0];
  assign wr_d1    = wr_en && (reg_idx == REG_DIVISOR_HIGH);
  assign wr_recip = wr_en && (reg_idx == REG_RECIPROCAL);

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q    <= {1'b1, {(LIMB_WIDTH-1){1'b0}}};
      d0_q    <= '0;
      recip_q <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIVISOR_HIGH: d1_q    <= wr_data;
        REG_DIVISOR_LOW:  d0_q    <= wr_data;
        REG_RECIPROCAL:   recip_q <= wr_data;
        default: ;
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_DIVISOR_HIGH: prdata = APB_DATA_WIDTH'(d1_q);
      REG_DIVISOR_LOW:  prdata = APB_DATA_WIDTH'(d0_q);
      REG_RECIPROCAL:   prdata = APB_DATA_WIDTH'(recip_q);
      default:          prdata = '0;
    endcase
  end

  assign d1_o    = d1_q;
  assign d0_o    = d0_q;
  assign recip_o = recip_q;

  // A completed write lands in the addressed register on the next cycle.
  `DTB_ASSERT_NEXT(a_d1_write, wr_d1, d1_q == $past(wr_data), "divisor high write lost")
  `DTB_ASSERT_NEXT(a_recip_write, wr_recip, recip_q == $past(wr_data), "reciprocal write lost")

endmodule

FILE: rtl/core/dtb_estimate.sv
// ============================================================================
// dtb_estimate
// Two pipeline stages forming the quotient estimate
// reciprocal * top + {top, mid}.
// ============================================================================
module dtb_estimate #(
  parameter int unsigned LIMB_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [LIMB_WIDTH-1:0] top_i,
  input  logic [LIMB_WIDTH-1:0] mid_i,
  input  logic [LIMB_WIDTH-1:0] bot_i,
  input  logic [LIMB_WIDTH-1:0] recip_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [LIMB_WIDTH-1:0] qhi_o,
  output logic [LIMB_WIDTH-1:0] qlo_o,
  output logic [LIMB_WIDTH-1:0] mid_o,
  output logic [LIMB_WIDTH-1:0] bot_o
);

  localparam int unsigned DW = 2 * LIMB_WIDTH;

  logic                  a_valid_q, b_valid_q;
  logic                  a_en, b_en;
  logic [DW-1:0]         a_prod_d, a_prod_q;
  logic [LIMB_WIDTH-1:0] a_top_q, a_mid_q, a_bot_q;
  logic [DW-1:0]         b_est_d, b_est_q;
  logic [LIMB_WIDTH-1:0] b_mid_q, b_bot_q;

  // A stage loads when it is empty or its contents move on.
  assign b_en    = !b_valid_q || ready_i;
  assign a_en    = !a_valid_q || b_en;
  assign ready_o = a_en;

  // Stage A multiplies, stage B adds the top two dividend limbs.
  assign a_prod_d = DW'(recip_i) * DW'(top_i);
  assign b_est_d  = a_prod_q + {a_top_q, a_mid_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= valid_i;
      if (b_en) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && valid_i) begin
      a_prod_q <= a_prod_d;
      a_top_q  <= top_i;
      a_mid_q  <= mid_i;
      a_bot_q  <= bot_i;
    end
    if (b_en && a_valid_q) begin
      b_est_q <= b_est_d;
      b_mid_q <= a_mid_q;
      b_bot_q <= a_bot_q;
    end
  end

  assign valid_o = b_valid_q;
  assign qhi_o   = b_est_q[DW-1:LIMB_WIDTH];
  assign qlo_o   = b_est_q[LIMB_WIDTH-1:0];
  assign mid_o   = b_mid_q;
  assign bot_o   = b_bot_q;

endmodule

FILE: rtl/core/dtb_reduce.sv
// ============================================================================
// dtb_reduce
// Three pipeline stages subtracting the estimate times the divisor, and the
// divisor once more, from the partial remainder.
// ============================================================================
module dtb_reduce #(
  parameter int unsigned LIMB_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [LIMB_WIDTH-1:0] qhi_i,
  input  logic [LIMB_WIDTH-1:0] qlo_i,
  input  logic [LIMB_WIDTH-1:0] mid_i,
  input  logic [LIMB_WIDTH-1:0] bot_i,
  input  logic [LIMB_WIDTH-1:0] d1_i,
  input  logic [LIMB_WIDTH-1:0] d0_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [LIMB_WIDTH-1:0] q_o,
  output logic [LIMB_WIDTH-1:0] qlo_o,
  output logic [2*LIMB_WIDTH-1:0] rem_o
);

  localparam int unsigned DW = 2 * LIMB_WIDTH;

  logic                  c_valid_q, d_valid_q, e_valid_q;
  logic                  c_en, d_en, e_en;
  logic [LIMB_WIDTH-1:0] c_m1;
  logic [DW-1:0]         c_m2;
  logic [LIMB_WIDTH-1:0] c_t1_q, c_qhi_q, c_qlo_q, c_mid_q, c_bot_q;
  logic [DW-1:0]         c_p2_q;
  logic [DW-1:0]         d_r0_q, d_sub_q;
  logic [LIMB_WIDTH-1:0] d_qhi_q, d_qlo_q;
  logic [DW-1:0]         e_rem_q;
  logic [LIMB_WIDTH-1:0] e_q_q, e_qlo_q;

  assign e_en    = !e_valid_q || ready_i;
  assign d_en    = !d_valid_q || e_en;
  assign c_en    = !c_valid_q || d_en;
  assign ready_o = c_en;

  // Stage C: the two limb products of the estimate with the divisor. Only the
  // low limb of the first one is needed.
  assign c_m1 = qhi_i * d1_i;
  assign c_m2 = DW'(d0_i) * DW'(qhi_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (c_en) c_valid_q <= valid_i;
      if (d_en) d_valid_q <= c_valid_q;
      if (e_en) e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en && valid_i) begin
      c_t1_q  <= c_m1;
      c_p2_q  <= c_m2;
      c_qhi_q <= qhi_i;
      c_qlo_q <= qlo_i;
      c_mid_q <= mid_i;
      c_bot_q <= bot_i;
    end
    // Stage D: partial remainder and the amount to take off it.
    if (d_en && c_valid_q) begin
      d_r0_q  <= {c_mid_q - c_t1_q, c_bot_q};
      d_sub_q <= c_p2_q + {d1_i, d0_i};
      d_qhi_q <= c_qhi_q;
      d_qlo_q <= c_qlo_q;
    end
    // Stage E: the subtraction, with the quotient bumped by one.
    if (e_en && d_valid_q) begin
      e_rem_q <= d_r0_q - d_sub_q;
      e_q_q   <= d_qhi_q + LIMB_WIDTH'(1);
      e_qlo_q <= d_qlo_q;
    end
  end

  assign valid_o = e_valid_q;
  assign q_o     = e_q_q;
  assign qlo_o   = e_qlo_q;
  assign rem_o   = e_rem_q;

endmodule

FILE: rtl/core/dtb_correct.sv
// ============================================================================
// dtb_correct
// Two pipeline stages applying the downward and the rare upward correction.
// The second stage is the output register.
// ============================================================================
module dtb_correct #(
  parameter int unsigned LIMB_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [LIMB_WIDTH-1:0]   q_i,
  input  logic [LIMB_WIDTH-1:0]   qlo_i,
  input  logic [2*LIMB_WIDTH-1:0] rem_i,
  input  logic [LIMB_WIDTH-1:0]   d1_i,
  input  logic [LIMB_WIDTH-1:0]   d0_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [LIMB_WIDTH-1:0]   q_o,
  output logic [2*LIMB_WIDTH-1:0] rem_o
);

  localparam int unsigned DW = 2 * LIMB_WIDTH;

  logic                  f_valid_q, g_valid_q;
  logic                  f_en, g_en;
  logic [DW-1:0]         div;
  logic                  down;
  logic                  up;
  logic [LIMB_WIDTH-1:0] f_q_q, g_q_q;
  logic [DW-1:0]         f_rem_q, g_rem_q;

  assign div     = {d1_i, d0_i};
  assign g_en    = !g_valid_q || ready_i;
  assign f_en    = !f_valid_q || g_en;
  assign ready_o = f_en;

  // Downward when the upper remainder limb reaches the low estimate limb.
  assign down = rem_i[DW-1:LIMB_WIDTH] >= qlo_i;
  // Upward when the remainder is still at or above the divisor.
  assign up   = f_rem_q >= div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else begin
      if (f_en) f_valid_q <= valid_i;
      if (g_en) g_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en && valid_i) begin
      if (down) begin
        f_q_q   <= q_i - LIMB_WIDTH'(1);
        f_rem_q <= rem_i + div;
      end else begin
        f_q_q   <= q_i;
        f_rem_q <= rem_i;
      end
    end
    if (g_en && f_valid_q) begin
      if (up) begin
        g_q_q   <= f_q_q + LIMB_WIDTH'(1);
        g_rem_q <= f_rem_q - div;
      end else begin
        g_q_q   <= f_q_q;
        g_rem_q <= f_rem_q;
      end
    end
  end

  assign valid_o = g_valid_q;
  assign q_o     = g_q_q;
  assign rem_o   = g_rem_q;

endmodule

FILE: rtl/core/divide_three_by_two_limb_preinverse_core.sv
// The core divides a three-limb dividend by a normalized two-limb divisor with
// a precomputed reciprocal and returns one quotient limb and a two-limb
// remainder per item. It takes one item every clock cycle while the output
// is not stalled and passes each one through a seven-stage pipeline: two
// stages for the quotient estimate (one multiplier), three for the product
// subtraction (two multipliers in the first), and two for the corrections,
// the last being the output register. Each stage holds its item while the
// next one is full, so a stalled output backs up without loss. The caller
// keeps the top two dividend limbs below the divisor and programs the
// reciprocal to match; neither is checked. Write the registers only while no
// item is in flight.
// ============================================================================
// divide_three_by_two_limb_preinverse_core
// Top level: register file, estimate, reduction and correction pipeline.
// ============================================================================
`include "divide_three_by_two_limb_preinverse_core_defines.svh"

module divide_three_by_two_limb_preinverse_core import dtb_pkg::*; #(
  parameter int unsigned LIMB_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  dtb_dividend_if.sink              dividend_i,
  dtb_result_if.source              result_o
);

  localparam int unsigned DW = 2 * LIMB_WIDTH;

  logic [LIMB_WIDTH-1:0] d1, d0, recip;
  logic                  est_valid, est_ready;
  logic [LIMB_WIDTH-1:0] est_qhi, est_qlo, est_mid, est_bot;
  logic                  red_valid, red_ready;
  logic [LIMB_WIDTH-1:0] red_q, red_qlo;
  logic [DW-1:0]         red_rem;
  logic [DW-1:0]         fin_rem;
  logic                  out_stall;

  // Configuration registers.
  dtb_regs #(.LIMB_WIDTH(LIMB_WIDTH)) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .d1_o    (d1),
    .d0_o    (d0),
    .recip_o (recip)
  );

  // Quotient estimate.
  dtb_estimate #(.LIMB_WIDTH(LIMB_WIDTH)) u_estimate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dividend_i.valid),
    .ready_o (dividend_i.ready),
    .top_i   (dividend_i.dividend_top),
    .mid_i   (dividend_i.dividend_mid),
    .bot_i   (dividend_i.dividend_bottom),
    .recip_i (recip),
    .valid_o (est_valid),
    .ready_i (est_ready),
    .qhi_o   (est_qhi),
    .qlo_o   (est_qlo),
    .mid_o   (est_mid),
    .bot_o   (est_bot)
  );

  // Product subtraction.
  dtb_reduce #(.LIMB_WIDTH(LIMB_WIDTH)) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (est_valid),
    .ready_o (est_ready),
    .qhi_i   (est_qhi),
    .qlo_i   (est_qlo),
    .mid_i   (est_mid),
    .bot_i   (est_bot),
    .d1_i    (d1),
    .d0_i    (d0),
    .valid_o (red_valid),
    .ready_i (red_ready),
    .q_o     (red_q),
    .qlo_o   (red_qlo),
    .rem_o   (red_rem)
  );

  // Corrections and output register.
  dtb_correct #(.LIMB_WIDTH(LIMB_WIDTH)) u_correct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (red_valid),
    .ready_o (red_ready),
    .q_i     (red_q),
    .qlo_i   (red_qlo),
    .rem_i   (red_rem),
    .d1_i    (d1),
    .d0_i    (d0),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .q_o     (result_o.quotient),
    .rem_o   (fin_rem)
  );

  assign result_o.remainder_high = fin_rem[DW-1:LIMB_WIDTH];
  assign result_o.remainder_low  = fin_rem[LIMB_WIDTH-1:0];

  // A result is waiting and the receiver holds it off.
  assign out_stall = result_o.valid && !result_o.ready;

  // Input back-pressure only arises from a full pipeline behind a stalled output.
  `DTB_ASSERT_SAME(a_stall_source, !dividend_i.ready, out_stall, "input stalled alone")

endmodule
